>>> rtl/twseg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the time window segmenter.
// No dependencies; imported by every module of the block.

package twseg_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int IV_W      = 47;
    localparam int WCNT_W    = 9;
    localparam int SLOT_W    = 8;
    localparam int SEGCNT_W  = 16;

    localparam logic [IV_W-1:0]   IV_RESET   = IV_W'(65536);
    localparam logic [WCNT_W-1:0] WCNT_RESET = WCNT_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_MODE    = 2'd0,
        CFG_INTERVAL     = 2'd1,
        CFG_FIRST_TIME   = 2'd2,
        CFG_WINDOW_COUNT = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_SAMPLE = 1'b1
    } cmd_t;

    // Control from the sequencer to the time generator.
    typedef struct packed {
        logic iv_wr;
        logic ft_wr;
        logic step;
    } tgen_ctl_t;

endpackage

>>> rtl/twseg_win_mem.sv
`timescale 1ns / 1ps
// Window table: start and end times, one write port and one registered read port.
// Depends on twseg_pkg.

module twseg_win_mem
    import twseg_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int TW    = 48
)
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic signed [TW-1:0] wr_start,
    input  logic signed [TW-1:0] wr_end,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output logic signed [TW-1:0] rd_start,
    output logic signed [TW-1:0] rd_end
);

    logic [TW-1:0] start_mem [DEPTH];
    logic [TW-1:0] end_mem   [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            start_mem[wr_addr] <= wr_start;
            end_mem[wr_addr]   <= wr_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_start <= start_mem[rd_addr];
            rd_end   <= end_mem[rd_addr];
        end
    end

endmodule

>>> rtl/twseg_timegen.sv
`timescale 1ns / 1ps
// Fixed-rate time generator: holds first_time and sample_interval and steps a
// saturating running time. Depends on twseg_pkg.

module twseg_timegen
    import twseg_pkg::*;
#(
    parameter int TW  = 48,
    parameter int CDW = 48
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tgen_ctl_t            ctl,
    input  logic [CDW-1:0]       wdata,
    output logic signed [TW-1:0] next_time
);

    localparam int SW = ((TW > IV_W) ? TW : IV_W) + 2;

    logic [IV_W-1:0]      interval_reg;
    logic signed [TW-1:0] first_time_reg;
    logic signed [TW-1:0] running_reg;
    logic                 pending_reg;

    logic [SW-1:0] sum;
    logic [SW-1:0] tmax;
    logic          sat;

    // The running time only grows, so only the upper bound can be crossed.
    assign sum  = {{(SW-TW){running_reg[TW-1]}}, running_reg} +
                  {{(SW-IV_W){1'b0}}, interval_reg};
    assign tmax = {{(SW-TW+1){1'b0}}, {(TW-1){1'b1}}};
    assign sat  = $signed(sum) > $signed(tmax);

    always_comb
    begin
        if (pending_reg)
            next_time = first_time_reg;
        else if (sat)
            next_time = tmax[TW-1:0];
        else
            next_time = sum[TW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg   <= IV_RESET;
            first_time_reg <= '0;
            pending_reg    <= 1'b1;
        end
        else
        begin
            if (ctl.iv_wr)
                interval_reg <= wdata[IV_W-1:0];
            if (ctl.ft_wr)
                first_time_reg <= wdata[TW-1:0];
            if (ctl.iv_wr || ctl.ft_wr)
                pending_reg <= 1'b1;
            else if (ctl.step)
                pending_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step)
            running_reg <= next_time;
    end

endmodule

>>> rtl/time_window_segmenter.sv
`timescale 1ns / 1ps
// Time window segmenter, top level. Depends on twseg_pkg, twseg_win_mem and
// twseg_timegen.
//
// Usage: words arrive on the item channel (item_valid / item_stall). A load
// word (cmd 0) writes window_start and window_end into window_slot and
// returns no result. A sample word (cmd 1) takes its time from sample_time,
// or from the fixed-rate generator when time_mode is set, and scans the
// window table one slot per cycle with a single signed range comparator,
// stopping at the first hit. At most window_count slots are compared, up to
// 256; each slot's times come through the table's registered read port. With
// no windows in use the sample goes straight to the final state.
// item_stall is high while a sample is scanned and finished.
// Results leave on the result channel (result_valid / result_stall) from an
// output register. A new word is taken while a result waits; if the next
// sample finishes before the old result is taken, the block holds in its
// final state until result_stall drops.
// Configuration writes (cfg_valid / cfg_ready, always ready) must be made
// while the block is idle; the block does not enforce this. Reset clears the
// segment state and counter and sets the registers to their reset values;
// the window table is undefined until loaded.

module time_window_segmenter
    import twseg_pkg::*;
#(
    parameter int MAX_WINDOWS = 256,
    parameter int TIME_WIDTH  = 48
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [((TIME_WIDTH > IV_W) ? TIME_WIDTH : IV_W)-1:0] cfg_data,

    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic                          cmd,
    input  logic [SLOT_W-1:0]             window_slot,
    input  logic signed [TIME_WIDTH-1:0]  window_start,
    input  logic signed [TIME_WIDTH-1:0]  window_end,
    input  logic signed [TIME_WIDTH-1:0]  sample_time,

    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          matched,
    output logic [SLOT_W-1:0]             window_index,
    output logic                          segment_opened,
    output logic                          segment_closed,
    output logic [SEGCNT_W-1:0]           segments_total,
    output logic signed [TIME_WIDTH-1:0]  time_used
);

    localparam int TW    = TIME_WIDTH;
    localparam int CDW   = (TIME_WIDTH > IV_W) ? TIME_WIDTH : IV_W;
    localparam int AW    = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int CNT_W = ((AW + 1) > (WCNT_W + 1)) ? (AW + 1) : (WCNT_W + 1);
    localparam logic [CNT_W-1:0] MAXW = CNT_W'(MAX_WINDOWS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic                 mode_reg, mode_next;
    logic [WCNT_W-1:0]    wcount_reg, wcount_next;
    logic signed [TW-1:0] t_reg, t_next;
    logic [CNT_W-1:0]     lim_reg, lim_next;
    logic [CNT_W-1:0]     issue_reg, issue_next;
    logic                 cmp_pend_reg, cmp_pend_next;
    logic [CNT_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                 found_reg, found_next;
    logic [CNT_W-1:0]     hit_reg, hit_next;
    logic                 seg_open_reg, seg_open_next;
    logic [CNT_W-1:0]     open_win_reg, open_win_next;
    logic [SEGCNT_W-1:0]  seg_cnt_reg, seg_cnt_next;
    logic                 rvalid_reg, rvalid_next;
    logic                 matched_reg, matched_next;
    logic [SLOT_W-1:0]    index_reg, index_next;
    logic                 opened_reg, opened_next;
    logic                 closed_reg, closed_next;
    logic signed [TW-1:0] time_reg, time_next;

    logic                 item_acc;
    logic                 cfg_wr;
    logic [CNT_W-1:0]     slot_ext;
    logic [CNT_W-1:0]     wcount_ext;
    logic                 mem_wr;
    logic                 mem_rd;
    logic signed [TW-1:0] rd_start;
    logic signed [TW-1:0] rd_end;
    logic                 in_range;
    logic signed [TW-1:0] gen_time;
    tgen_ctl_t            tg_ctl;

    assign cfg_ready  = 1'b1;
    assign cfg_wr     = cfg_valid && cfg_ready;
    assign item_stall = (state_reg != ST_IDLE);
    assign item_acc   = item_valid && !item_stall;

    assign slot_ext   = CNT_W'(window_slot);
    assign wcount_ext = CNT_W'(wcount_reg);
    assign mem_wr     = item_acc && (cmd == CMD_LOAD) && (slot_ext < MAXW);
    assign mem_rd     = (state_reg == ST_SCAN) && (issue_reg < lim_reg);

    // The one shared comparator of the scan.
    assign in_range   = (t_reg >= rd_start) && (t_reg <= rd_end);

    assign tg_ctl.iv_wr = cfg_wr && (cfg_index == CFG_INTERVAL);
    assign tg_ctl.ft_wr = cfg_wr && (cfg_index == CFG_FIRST_TIME);
    assign tg_ctl.step  = item_acc && (cmd == CMD_SAMPLE) && mode_reg;

    twseg_win_mem #(
        .DEPTH (MAX_WINDOWS),
        .AW    (AW),
        .TW    (TW)
    ) u_mem (
        .clk      (clk),
        .wr_en    (mem_wr),
        .wr_addr  (slot_ext[AW-1:0]),
        .wr_start (window_start),
        .wr_end   (window_end),
        .rd_en    (mem_rd),
        .rd_addr  (issue_reg[AW-1:0]),
        .rd_start (rd_start),
        .rd_end   (rd_end)
    );

    twseg_timegen #(
        .TW  (TW),
        .CDW (CDW)
    ) u_timegen (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (tg_ctl),
        .wdata     (cfg_data),
        .next_time (gen_time)
    );

    always_comb
    begin
        logic seg_still_open;

        state_next    = state_reg;
        mode_next     = mode_reg;
        wcount_next   = wcount_reg;
        t_next        = t_reg;
        lim_next      = lim_reg;
        issue_next    = issue_reg;
        cmp_pend_next = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        found_next    = found_reg;
        hit_next      = hit_reg;
        seg_open_next = seg_open_reg;
        open_win_next = open_win_reg;
        seg_cnt_next  = seg_cnt_reg;
        rvalid_next   = rvalid_reg && result_stall;
        matched_next  = matched_reg;
        index_next    = index_reg;
        opened_next   = opened_reg;
        closed_next   = closed_reg;
        time_next     = time_reg;
        seg_still_open = 1'b0;

        if (cfg_wr)
        begin
            case (cfg_index)
                CFG_TIME_MODE:    mode_next   = cfg_data[0];
                CFG_WINDOW_COUNT: wcount_next = cfg_data[WCNT_W-1:0];
                default:          ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_acc && (cmd == CMD_SAMPLE))
                begin
                    t_next     = mode_reg ? gen_time : sample_time;
                    lim_next   = (wcount_ext > MAXW) ? MAXW : wcount_ext;
                    issue_next = '0;
                    found_next = 1'b0;
                    hit_next   = '0;
                    // With no windows in use there is nothing to scan.
                    state_next = (wcount_reg == '0) ? ST_FINISH : ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (mem_rd)
                begin
                    issue_next    = issue_reg + 1'b1;
                    cmp_pend_next = 1'b1;
                    cmp_idx_next  = issue_reg;
                end
                if (cmp_pend_reg && in_range)
                begin
                    found_next = 1'b1;
                    hit_next   = cmp_idx_reg;
                    state_next = ST_FINISH;
                end
                else if (cmp_pend_reg && (cmp_idx_reg + 1'b1 == lim_reg))
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!rvalid_reg || !result_stall)
                begin
                    opened_next = 1'b0;
                    closed_next = 1'b0;
                    if (found_reg)
                    begin
                        closed_next    = seg_open_reg && (hit_reg != open_win_reg);
                        seg_still_open = seg_open_reg && (hit_reg == open_win_reg);
                        if (!seg_still_open)
                        begin
                            opened_next   = 1'b1;
                            open_win_next = hit_reg;
                            if (seg_cnt_reg != {SEGCNT_W{1'b1}})
                                seg_cnt_next = seg_cnt_reg + 1'b1;
                        end
                        seg_open_next = 1'b1;
                    end
                    else
                    begin
                        closed_next   = seg_open_reg;
                        seg_open_next = 1'b0;
                    end
                    matched_next = found_reg;
                    index_next   = found_reg ? hit_reg[SLOT_W-1:0] : '0;
                    time_next    = t_reg;
                    rvalid_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mode_reg     <= 1'b0;
            wcount_reg   <= WCNT_RESET;
            t_reg        <= '0;
            lim_reg      <= '0;
            issue_reg    <= '0;
            cmp_pend_reg <= 1'b0;
            cmp_idx_reg  <= '0;
            found_reg    <= 1'b0;
            hit_reg      <= '0;
            seg_open_reg <= 1'b0;
            open_win_reg <= '0;
            seg_cnt_reg  <= '0;
            rvalid_reg   <= 1'b0;
            matched_reg  <= 1'b0;
            index_reg    <= '0;
            opened_reg   <= 1'b0;
            closed_reg   <= 1'b0;
            time_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            wcount_reg   <= wcount_next;
            t_reg        <= t_next;
            lim_reg      <= lim_next;
            issue_reg    <= issue_next;
            cmp_pend_reg <= cmp_pend_next;
            cmp_idx_reg  <= cmp_idx_next;
            found_reg    <= found_next;
            hit_reg      <= hit_next;
            seg_open_reg <= seg_open_next;
            open_win_reg <= open_win_next;
            seg_cnt_reg  <= seg_cnt_next;
            rvalid_reg   <= rvalid_next;
            matched_reg  <= matched_next;
            index_reg    <= index_next;
            opened_reg   <= opened_next;
            closed_reg   <= closed_next;
            time_reg     <= time_next;
        end
    end

    assign result_valid   = rvalid_reg;
    assign matched        = matched_reg;
    assign window_index   = index_reg;
    assign segment_opened = opened_reg;
    assign segment_closed = closed_reg;
    assign segments_total = seg_cnt_reg;
    assign time_used      = time_reg;

    // A new result is only ever loaded by the final state of a sample.
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rvalid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result appeared outside the final state");

    // An unmatched sample reports slot zero and never opens a segment.
    a_unmatched_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (rvalid_reg && !matched_reg) |-> (index_reg == '0) && !opened_reg)
        else $error("unmatched result carries an index or an opened segment");

    // The counter moves only when a result is produced, by exactly one.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(seg_cnt_reg) |->
            ($past(state_reg) == ST_FINISH) && (seg_cnt_reg == $past(seg_cnt_reg) + 1'b1))
        else $error("segment counter changed unexpectedly");

    // The scan never reads past the number of windows in use.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (issue_reg <= lim_reg) && (lim_reg <= MAXW))
        else $error("scan index beyond window limit");

    // A segment opens exactly when the sample matches a window it was not already in.
    a_open_sets_state: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(rvalid_reg) && opened_reg) |-> seg_open_reg && (open_win_reg == hit_reg))
        else $error("opened segment not recorded");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for time_window_segmenter: window loads and samples in both
// time modes, checked against a cycle-free predictor kept in step with accepted words.
// Depends on twseg_pkg and the time_window_segmenter RTL.

module tb;
    import twseg_pkg::*;

    localparam int     TW         = 48;
    localparam longint T_MAX      = (longint'(1) <<< 47) - 1;
    localparam longint T_MIN      = -T_MAX - 1;
    localparam int     QUIET_MAX  = 3000;
    localparam int     RAND_WORDS = 850;

    typedef logic signed [TW-1:0] stamp_t;

    typedef struct {
        cmd_t             op;
        logic [SLOT_W-1:0] slot;
        stamp_t           lo;
        stamp_t           hi;
        stamp_t           stime;
        bit               hold;
    } seg_word_t;

    typedef struct {
        logic                matched;
        logic [SLOT_W-1:0]   index;
        logic                opened;
        logic                closed;
        logic [SEGCNT_W-1:0] total;
        stamp_t              stamp;
    } seg_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TW-1:0]        cfg_data = '0;

    logic              item_valid = 1'b0;
    logic              item_stall;
    logic              cmd = 1'b0;
    logic [SLOT_W-1:0] window_slot = '0;
    stamp_t            window_start = '0;
    stamp_t            window_end = '0;
    stamp_t            sample_time = '0;

    logic                result_valid;
    logic                result_stall = 1'b0;
    logic                matched;
    logic [SLOT_W-1:0]   window_index;
    logic                segment_opened;
    logic                segment_closed;
    logic [SEGCNT_W-1:0] segments_total;
    stamp_t              time_used;

    // Predictor state, shadowing the block's registers and table.
    stamp_t              win_lo [256];
    stamp_t              win_hi [256];
    logic                fixed_rate = 1'b0;
    logic [IV_W-1:0]     step_size = IV_RESET;
    stamp_t              first_stamp = '0;
    logic [WCNT_W-1:0]   win_in_use = WCNT_RESET;
    bit                  restart_due = 1'b1;
    stamp_t              gen_now = '0;
    bit                  seg_live = 1'b0;
    int                  live_win = 0;
    logic [SEGCNT_W-1:0] seg_count = '0;

    // Stimulus side: what has been queued into the table so far.
    longint gen_lo [256];
    longint gen_hi [256];
    bit     written [256];
    int     focus = 0;

    seg_word_t   word_backlog [$];
    seg_result_t segment_due [$];
    seg_word_t   on_wire;
    int          words_queued = 0;
    int          words_taken = 0;
    int          errors = 0;
    int          gap_left = 0;
    int          burst_left = 0;
    int          quiet = 0;
    logic [9:0]  stall_phase = '0;

    time_window_segmenter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .cmd            (cmd),
        .window_slot    (window_slot),
        .window_start   (window_start),
        .window_end     (window_end),
        .sample_time    (sample_time),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .matched        (matched),
        .window_index   (window_index),
        .segment_opened (segment_opened),
        .segment_closed (segment_closed),
        .segments_total (segments_total),
        .time_used      (time_used)
    );

    always #5 clk = ~clk;

    function automatic stamp_t clamp_stamp(longint v);
        if (v > T_MAX)
        begin
            return stamp_t'(T_MAX);
        end
        if (v < T_MIN)
        begin
            return stamp_t'(T_MIN);
        end
        return stamp_t'(v);
    endfunction

    function automatic stamp_t rand_stamp();
        return stamp_t'({$urandom, $urandom});
    endfunction

    task automatic flag_mismatch(string what, longint got, longint want);
        errors++;
        $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
    endtask

    // Advances the predictor by one accepted word and queues the result it yields.
    task automatic predict_word(seg_word_t w);
        seg_result_t r;
        stamp_t      t;
        int          span;
        int          hit;
        if (w.op == CMD_LOAD)
        begin
            win_lo[w.slot] = w.lo;
            win_hi[w.slot] = w.hi;
            return;
        end
        if (fixed_rate)
        begin
            if (restart_due)
            begin
                t = first_stamp;
            end
            else if (longint'(gen_now) + longint'(step_size) > T_MAX)
            begin
                t = stamp_t'(T_MAX);
            end
            else
            begin
                t = stamp_t'(longint'(gen_now) + longint'(step_size));
            end
            gen_now = t;
            restart_due = 1'b0;
        end
        else
        begin
            t = w.stime;
        end
        span = (win_in_use > 256) ? 256 : int'(win_in_use);
        hit = -1;
        for (int i = 0; i < span; i++)
        begin
            if (hit < 0 && t >= win_lo[i] && t <= win_hi[i])
            begin
                hit = i;
            end
        end
        r.matched = (hit >= 0);
        r.index = (hit >= 0) ? SLOT_W'(hit) : '0;
        r.opened = 1'b0;
        r.closed = 1'b0;
        if (hit >= 0)
        begin
            if (seg_live && hit != live_win)
            begin
                r.closed = 1'b1;
                seg_live = 1'b0;
            end
            if (!seg_live)
            begin
                r.opened = 1'b1;
                seg_live = 1'b1;
                live_win = hit;
                if (seg_count != '1)
                begin
                    seg_count++;
                end
            end
        end
        else
        begin
            r.closed = seg_live;
            seg_live = 1'b0;
        end
        r.total = seg_count;
        r.stamp = t;
        segment_due.push_back(r);
    endtask

    task automatic reg_write(cfg_reg_t which, logic [TW-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (which)
            CFG_TIME_MODE:    fixed_rate = value[0];
            CFG_INTERVAL:
            begin
                step_size = value[IV_W-1:0];
                restart_due = 1'b1;
            end
            CFG_FIRST_TIME:
            begin
                first_stamp = value;
                restart_due = 1'b1;
            end
            CFG_WINDOW_COUNT: win_in_use = value[WCNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic queue_load(logic [SLOT_W-1:0] slot, stamp_t lo, stamp_t hi);
        seg_word_t w;
        w.op = CMD_LOAD;
        w.slot = slot;
        w.lo = lo;
        w.hi = hi;
        w.stime = rand_stamp();
        w.hold = 1'b0;
        gen_lo[slot] = longint'(lo);
        gen_hi[slot] = longint'(hi);
        written[slot] = 1'b1;
        word_backlog.push_back(w);
        words_queued++;
    endtask

    task automatic queue_sample(stamp_t t, bit hold);
        seg_word_t w;
        w.op = CMD_SAMPLE;
        w.slot = SLOT_W'($urandom);
        w.lo = rand_stamp();
        w.hi = rand_stamp();
        w.stime = t;
        w.hold = hold;
        word_backlog.push_back(w);
        words_queued++;
    endtask

    // Waits until every queued word is taken and every result is back, then lets a
    // trailing load finish before the caller touches the registers.
    task automatic settle();
        while (words_taken != words_queued || segment_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    // Lays windows over positions base + n * step, with gaps, overlaps, empty
    // ranges and the odd window anywhere in the time range.
    task automatic lay_windows(longint base, longint step, int count);
        longint pos;
        longint gap;
        longint len;
        longint lo;
        longint hi;
        longint tmp;
        pos = 0;
        for (int j = 0; j < count; j++)
        begin
            gap = $urandom_range(0, 2);
            len = $urandom_range(0, 5);
            if (pos > 3 && $urandom_range(0, 4) == 0)
            begin
                pos = pos - $urandom_range(1, 3);
            end
            lo = base + (pos + gap) * step;
            hi = base + (pos + gap + len) * step;
            case ($urandom_range(0, 7))
                0: hi = hi - 1;
                1:
                begin
                    tmp = lo;
                    lo = hi;
                    hi = tmp;
                end
                2:
                begin
                    lo = longint'(rand_stamp());
                    hi = longint'(rand_stamp());
                end
                default: ;
            endcase
            queue_load(SLOT_W'(j), clamp_stamp(lo), clamp_stamp(hi));
            pos = pos + gap + len + 1;
        end
    endtask

    // Sample times for input mode: mostly inside or on the edges of one window,
    // staying on the same window for a while so that segments last.
    function automatic stamp_t pick_time(int count);
        longint t;
        if (count == 0 || $urandom_range(0, 9) == 0)
        begin
            return rand_stamp();
        end
        if ($urandom_range(0, 9) < 3 || focus >= count)
        begin
            focus = $urandom_range(0, count - 1);
        end
        case ($urandom_range(0, 7))
            0: t = gen_lo[focus];
            1: t = gen_hi[focus];
            2: t = gen_lo[focus] - 1;
            3: t = gen_hi[focus] + 1;
            default:
            begin
                if (gen_hi[focus] > gen_lo[focus])
                begin
                    t = gen_lo[focus]
                        + (longint'($urandom) % (gen_hi[focus] - gen_lo[focus] + 1));
                end
                else
                begin
                    t = gen_lo[focus];
                end
            end
        endcase
        return clamp_stamp(t);
    endfunction

    // Word driver: bursts of random length separated by random gaps.
    always @(posedge clk)
    begin : feed
        seg_word_t nxt;
        logic      go;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                predict_word(on_wire);
                words_taken++;
            end
            if (!item_valid || !item_stall)
            begin
                go = 1'b0;
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (word_backlog.size() != 0
                         && !(word_backlog[0].hold && segment_due.size() != 0))
                begin
                    nxt = word_backlog.pop_front();
                    on_wire = nxt;
                    cmd <= nxt.op;
                    window_slot <= nxt.slot;
                    window_start <= nxt.lo;
                    window_end <= nxt.hi;
                    sample_time <= nxt.stime;
                    go = 1'b1;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, 11);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
                item_valid <= go;
            end
        end
    end

    // Result stall pattern: free-flowing, light, heavy and long blocked stretches.
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 1'b1;
        case (stall_phase[9:8])
            2'd0: result_stall <= 1'b0;
            2'd1: result_stall <= ($urandom_range(0, 3) == 0);
            2'd2: result_stall <= ($urandom_range(0, 1) == 1);
            default: result_stall <= (stall_phase[4:2] >= 3'd5);
        endcase
    end

    always @(posedge clk)
    begin : check
        seg_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (segment_due.size() == 0)
            begin
                flag_mismatch("unexpected result word", 1, 0);
            end
            else
            begin
                want = segment_due.pop_front();
                if (matched !== want.matched)
                begin
                    flag_mismatch("matched", matched, want.matched);
                end
                if (window_index !== want.index)
                begin
                    flag_mismatch("window_index", window_index, want.index);
                end
                if (segment_opened !== want.opened)
                begin
                    flag_mismatch("segment_opened", segment_opened, want.opened);
                end
                if (segment_closed !== want.closed)
                begin
                    flag_mismatch("segment_closed", segment_closed, want.closed);
                end
                if (segments_total !== want.total)
                begin
                    flag_mismatch("segments_total", segments_total, want.total);
                end
                if (time_used !== want.stamp)
                begin
                    flag_mismatch("time_used", time_used, want.stamp);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
            begin
                quiet <= 0;
            end
            else if (quiet >= QUIET_MAX)
            begin
                $display("time_window_segmenter regression: fail");
                $finish;
            end
            else
            begin
                quiet <= quiet + 1;
            end
        end
    end

    initial
    begin
        int          start_words;
        int          phase;
        int          wc;
        int          nw;
        int          lim;
        int          nsamp;
        bit          fixed;
        longint      base;
        longint      step;
        logic [TW-1:0] iv_word;

        for (int i = 0; i < 256; i++)
        begin
            win_lo[i] = '0;
            win_hi[i] = '0;
            written[i] = 1'b0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: overlaps, edges, extremes, empty window, count of zero.
        reg_write(CFG_WINDOW_COUNT, 5);
        queue_load(0, -100, 100);
        queue_load(1, 50, 200);
        queue_load(2, stamp_t'(T_MIN), stamp_t'(T_MIN + 10));
        queue_load(3, stamp_t'(T_MAX - 10), stamp_t'(T_MAX));
        queue_load(4, 10, 5);
        queue_sample(0, 1'b0);
        queue_sample(100, 1'b0);
        queue_sample(101, 1'b0);
        queue_sample(201, 1'b0);
        queue_sample(202, 1'b0);
        queue_sample(stamp_t'(T_MIN), 1'b0);
        queue_sample(stamp_t'(T_MAX), 1'b0);
        queue_sample(-100, 1'b0);
        queue_sample(-101, 1'b0);
        queue_sample(7, 1'b1);
        queue_load(0, 500, 400);
        queue_sample(50, 1'b0);
        queue_sample(450, 1'b0);
        settle();
        reg_write(CFG_TIME_MODE, 1);
        reg_write(CFG_WINDOW_COUNT, 4);
        reg_write(CFG_FIRST_TIME, stamp_t'(T_MAX - 5));
        reg_write(CFG_INTERVAL, 3);
        repeat (3) queue_sample(rand_stamp(), 1'b0);
        settle();
        reg_write(CFG_INTERVAL, 0);
        repeat (2) queue_sample(rand_stamp(), 1'b0);
        settle();
        reg_write(CFG_TIME_MODE, 0);
        reg_write(CFG_WINDOW_COUNT, 0);
        queue_sample(0, 1'b0);

        // Random phases, each with its own register settings and window layout.
        start_words = words_queued;
        phase = 0;
        while (words_queued - start_words < RAND_WORDS)
        begin
            settle();
            phase++;
            case (phase)
                2: wc = 256;
                4: wc = 511;
                6: wc = 0;
                default: wc = $urandom_range(1, 12);
            endcase
            fixed = ($urandom_range(0, 2) == 0);
            case ($urandom_range(0, 7))
                0:
                begin
                    base = T_MIN;
                    step = T_MAX;
                end
                1:
                begin
                    base = longint'(rand_stamp());
                    step = 0;
                end
                2:
                begin
                    base = T_MAX - $urandom_range(0, 40);
                    step = $urandom_range(1, 8);
                end
                default:
                begin
                    base = longint'(rand_stamp()) >>> 8;
                    step = $urandom_range(1, 1 << 20);
                end
            endcase
            reg_write(CFG_WINDOW_COUNT, TW'(wc));
            reg_write(CFG_TIME_MODE, TW'(fixed));
            if (fixed || $urandom_range(0, 3) == 0)
            begin
                iv_word = TW'(step);
                iv_word[TW-1] = $urandom_range(0, 1);
                reg_write(CFG_INTERVAL, iv_word);
                reg_write(CFG_FIRST_TIME, clamp_stamp(base));
            end
            nw = (wc > 12) ? 12 : wc;
            lay_windows(base, step, nw);
            lim = (wc > 256) ? 256 : wc;
            for (int s = 0; s < lim; s++)
            begin
                if (!written[s])
                begin
                    queue_load(SLOT_W'(s), rand_stamp(), rand_stamp());
                end
            end
            nsamp = (wc > 12) ? 12 : $urandom_range(8, 30);
            for (int n = 0; n < nsamp; n++)
            begin
                if ($urandom_range(0, 24) == 0)
                begin
                    queue_load(SLOT_W'($urandom_range(0, 255)), rand_stamp(), rand_stamp());
                end
                queue_sample(fixed ? rand_stamp() : pick_time(nw), $urandom_range(0, 49) == 0);
            end
        end

        settle();
        repeat (300) @(posedge clk);
        if (errors == 0 && segment_due.size() == 0)
        begin
            $display("time_window_segmenter regression: pass");
        end
        else
        begin
            $display("time_window_segmenter regression: fail");
        end
        $finish;
    end

endmodule
